[rtl/core/bdhr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdhr_pkg
// Shared types, status codes and register indexes for the button debounce,
// hold and repeat block.
// ----------------------------------------------------------------------------
package bdhr_pkg;

   localparam int NOW_W     = 32;
   localparam int ANALOG_W  = 10;
   localparam int STATUS_W  = 3;
   localparam int TIME_W    = 16;
   localparam int KIND_W    = 2;
   localparam int COUNT_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam int CLICK_RATIO_DEF = 4;

   // analog window half width
   localparam logic [ANALOG_W:0] ANALOG_WINDOW = 11'd50;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_UP       = 3'd0;
   localparam status_type ST_DEBOUNCE = 3'd1;
   localparam status_type ST_DOWN     = 3'd2;
   localparam status_type ST_HELD     = 3'd3;
   localparam status_type ST_RELEASED = 3'd4;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type KIND_DIGITAL = 2'd0;
   localparam kind_type KIND_ANALOG  = 2'd1;
   localparam kind_type KIND_NULL    = 2'd2;
   localparam kind_type KIND_AUTO    = 2'd3;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_BUTTON_KIND   = 3'd0;
   localparam csr_idx_type CSR_PRESSED_LEVEL = 3'd1;
   localparam csr_idx_type CSR_ANALOG_CENTER = 3'd2;
   localparam csr_idx_type CSR_DEBOUNCE_TIME = 3'd3;
   localparam csr_idx_type CSR_HOLD_TIME     = 3'd4;
   localparam csr_idx_type CSR_REPEAT_TIME   = 3'd5;
   localparam csr_idx_type CSR_DASH_TIME     = 3'd6;
   localparam csr_idx_type CSR_DASH_COUNT    = 3'd7;

endpackage

[rtl/core/button_debounce_hold_repeat.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_hold_repeat
// Debounced button with first-hold delay, repeat and dash repeat, plus
// analog window, null and periodic auto-click button kinds.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_stall | req_now_ms, req_pin_level, req_analog_sample
//  rsp     | out | rsp_valid/rsp_stall | rsp_button_status
//  csr     | in  | csr_wr_en           | csr_addr, csr_wdata
//
//  One beat per cycle sustained while rsp is not stalled; req goes to rsp via the sample and rsp registers.
//  Sample register feeds one pass of state update logic into the rsp register.
//  Synchronous active-high reset clears state and valid flags and loads config defaults.
//  A stalled rsp holds; req keeps accepting while the sample register is free.
// ----------------------------------------------------------------------------
module button_debounce_hold_repeat #(
   parameter int CLICK_RATIO = bdhr_pkg::CLICK_RATIO_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bdhr_pkg::NOW_W-1:0]           req_now_ms,
   input  logic                                 req_pin_level,
   input  logic [bdhr_pkg::ANALOG_W-1:0]        req_analog_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bdhr_pkg::STATUS_W-1:0]        rsp_button_status,
   input  logic                                 csr_wr_en,
   input  logic [bdhr_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [bdhr_pkg::CSR_DAT_W-1:0]       csr_wdata
);
   import bdhr_pkg::*;

   localparam int PERIOD_W = TIME_W + $clog2(CLICK_RATIO + 1);
   localparam logic [PERIOD_W-1:0] RATIO = PERIOD_W'(CLICK_RATIO);
   localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(CLICK_RATIO * 200);

   // configuration
   kind_type              kind_ff;
   logic                  level_ff;
   logic [ANALOG_W-1:0]   center_ff;
   logic [TIME_W-1:0]     debounce_ff;
   logic [TIME_W-1:0]     hold_ff;
   logic [TIME_W-1:0]     repeat_ff;
   logic [TIME_W-1:0]     dash_ff;
   logic [COUNT_W-1:0]    dash_cnt_ff;
   logic [PERIOD_W-1:0]   period_ff;

   // sample register
   logic                  s1_valid_ff;
   logic [NOW_W-1:0]      s1_now_ff;
   logic                  s1_pin_ff;
   logic [ANALOG_W-1:0]   s1_sample_ff;

   // button state
   status_type            status_ff,  status_in;
   logic [NOW_W-1:0]      down_ff,    down_in;
   logic [NOW_W-1:0]      last_ff,    last_in;
   logic                  holding_ff, holding_in;
   logic [COUNT_W-1:0]    rcount_ff,  rcount_in;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;

   logic                  advance;
   logic                  take_req;

   assign advance   = s1_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign take_req  = req_valid && !req_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_button_status = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff     <= KIND_DIGITAL;
         level_ff    <= 1'b0;
         center_ff   <= 10'd512;
         debounce_ff <= 16'd50;
         hold_ff     <= 16'd1000;
         repeat_ff   <= 16'd200;
         dash_ff     <= 16'd50;
         dash_cnt_ff <= 8'd5;
         period_ff   <= PERIOD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_BUTTON_KIND:   kind_ff     <= csr_wdata[KIND_W-1:0];
            CSR_PRESSED_LEVEL: level_ff    <= csr_wdata[0];
            CSR_ANALOG_CENTER: center_ff   <= csr_wdata[ANALOG_W-1:0];
            CSR_DEBOUNCE_TIME: debounce_ff <= csr_wdata;
            CSR_HOLD_TIME:     hold_ff     <= csr_wdata;
            CSR_REPEAT_TIME: begin
               repeat_ff <= csr_wdata;
               period_ff <= PERIOD_W'(RATIO * {{(PERIOD_W-TIME_W){1'b0}}, csr_wdata});
            end
            CSR_DASH_TIME:     dash_ff     <= csr_wdata;
            CSR_DASH_COUNT:    dash_cnt_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take_req) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_now_ff    <= req_now_ms;
         s1_pin_ff    <= req_pin_level;
         s1_sample_ff <= req_analog_sample;
      end
   end

   // ---- one pass of state update ----
   logic [NOW_W-1:0]    lat;
   logic [NOW_W-1:0]    auto_base;
   logic [NOW_W-1:0]    elapsed;
   logic [NOW_W-1:0]    auto_elapsed;
   logic [ANALOG_W:0]   samp_ext;
   logic [ANALOG_W:0]   cent_ext;
   logic                sensed;
   logic                press;
   logic [TIME_W-1:0]   thr;

   always_comb begin
      status_in  = status_ff;
      down_in    = down_ff;
      holding_in = holding_ff;
      rcount_in  = rcount_ff;

      // backwards time drops the last action mark
      lat     = (s1_now_ff < last_ff) ? '0 : last_ff;
      last_in = lat;

      samp_ext = {1'b0, s1_sample_ff};
      cent_ext = {1'b0, center_ff};
      if (kind_ff == KIND_ANALOG) begin
         sensed = (samp_ext + ANALOG_WINDOW >= cent_ext) &&
                  (samp_ext <= cent_ext + ANALOG_WINDOW);
      end else begin
         sensed = s1_pin_ff;
      end
      press = (sensed == level_ff);

      elapsed = s1_now_ff - down_ff;
      thr     = holding_ff ? ((rcount_ff > dash_cnt_ff) ? dash_ff : repeat_ff) : hold_ff;

      auto_base = (s1_now_ff < down_ff) ? '0 : down_ff;
      if (auto_base < lat) begin
         auto_base = lat;
      end
      auto_elapsed = s1_now_ff - auto_base;

      if (kind_ff == KIND_NULL) begin
         status_in = ST_UP;
      end else if (kind_ff == KIND_AUTO) begin
         if (auto_elapsed > {{(NOW_W-PERIOD_W){1'b0}}, period_ff}) begin
            down_in   = s1_now_ff;
            status_in = ST_RELEASED;
         end else begin
            down_in   = auto_base;
            status_in = ST_DOWN;
         end
      end else begin
         unique case (status_ff)
            ST_UP: begin
               holding_in = 1'b0;
               rcount_in  = '0;
               if (press) begin
                  status_in = ST_DEBOUNCE;
                  down_in   = s1_now_ff;
                  last_in   = s1_now_ff;
               end
            end
            ST_DEBOUNCE: begin
               if (!press) begin
                  status_in = ST_UP;
               end else if (elapsed > {{(NOW_W-TIME_W){1'b0}}, debounce_ff}) begin
                  status_in = ST_DOWN;
               end
            end
            ST_DOWN: begin
               last_in = s1_now_ff;
               if (!press) begin
                  status_in = holding_ff ? ST_UP : ST_RELEASED;
               end else if (elapsed > {{(NOW_W-TIME_W){1'b0}}, thr}) begin
                  status_in = ST_HELD;
                  // saturating repeat count
                  if (rcount_ff <= dash_cnt_ff && rcount_ff != '1) begin
                     rcount_in = rcount_ff + 1'b1;
                  end
               end
            end
            ST_HELD: begin
               holding_in = 1'b1;
               last_in    = s1_now_ff;
               if (press) begin
                  status_in = ST_DOWN;
                  down_in   = s1_now_ff;
               end else begin
                  status_in = ST_RELEASED;
               end
            end
            ST_RELEASED: begin
               status_in  = ST_UP;
               last_in    = s1_now_ff;
               holding_in = 1'b0;
               rcount_in  = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= ST_UP;
         down_ff    <= '0;
         last_ff    <= '0;
         holding_ff <= 1'b0;
         rcount_ff  <= '0;
      end else if (advance) begin
         status_ff  <= status_in;
         down_ff    <= down_in;
         last_ff    <= last_in;
         holding_ff <= holding_in;
         rcount_ff  <= rcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= status_in;
      end
   end

endmodule

[rtl/core/bdhr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdhr_checker
// Port-level checks for the button debounce, hold and repeat block.
// ----------------------------------------------------------------------------
module bdhr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [bdhr_pkg::STATUS_W-1:0]   rsp_button_status
);
   import bdhr_pkg::*;

   // nothing comes out of reset holding a beat
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_button_status <= ST_RELEASED)
      else $error("undefined button status");

   // accepted beat passes through the sample register to rsp when rsp is free
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted beat did not reach rsp");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_button_status))
      else $error("stalled rsp beat changed");

endmodule

bind button_debounce_hold_repeat bdhr_checker u_bdhr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_button_status (rsp_button_status)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the debounced button with hold, repeat and dash.
// A driver feeds timestamped samples from a queue, a local button model
// predicts the status of every accepted beat, and a monitor compares each
// returned status with the oldest prediction. Both handshakes idle at random.
// Register settings change only between bursts, once the block is drained.
// ----------------------------------------------------------------------------
module tb;
   import bdhr_pkg::*;

   localparam int CLICK_RATIO = CLICK_RATIO_DEF;
   localparam int DRAIN_TAIL = 6;
   localparam int DRAIN_LIMIT = 20000;

   typedef struct packed {
      logic [NOW_W-1:0]    now_ms;
      logic                pin_level;
      logic [ANALOG_W-1:0] analog_sample;
   } press_sample_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [NOW_W-1:0]      req_now_ms = '0;
   logic                  req_pin_level = 1'b0;
   logic [ANALOG_W-1:0]   req_analog_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_button_status;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr = '0;
   logic [CSR_DAT_W-1:0]  csr_wdata = '0;

   // settings as last written
   kind_type              cfg_kind = KIND_DIGITAL;
   logic                  cfg_level = 1'b0;
   logic [ANALOG_W-1:0]   cfg_center = 10'd512;
   logic [TIME_W-1:0]     cfg_debounce = 16'd50;
   logic [TIME_W-1:0]     cfg_hold = 16'd1000;
   logic [TIME_W-1:0]     cfg_repeat = 16'd200;
   logic [TIME_W-1:0]     cfg_dash = 16'd50;
   logic [COUNT_W-1:0]    cfg_dash_count = 8'd5;

   // button model state
   status_type            btn_status = ST_UP;
   logic [NOW_W-1:0]      btn_down_ms = '0;
   logic [NOW_W-1:0]      btn_last_ms = '0;
   logic                  btn_holding = 1'b0;
   logic [COUNT_W-1:0]    btn_repeats = '0;

   press_sample_type      sample_queue[$];
   status_type            status_due[$];
   press_sample_type      drv_beat;
   status_type            mon_want;
   int                    error_count = 0;
   logic                  calm = 1'b0;
   logic [NOW_W-1:0]      stamp = '0;
   int unsigned           gap_max = 4;
   int                    pushed = 0;

   always #1 clock = ~clock;

   button_debounce_hold_repeat #(.CLICK_RATIO(CLICK_RATIO)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_now_ms        (req_now_ms),
      .req_pin_level     (req_pin_level),
      .req_analog_sample (req_analog_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_button_status (rsp_button_status),
      .csr_wr_en         (csr_wr_en),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata)
   );

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic take_break();
      return !calm && ($urandom_range(99) < 9);
   endfunction

   // advances the button model by one sample and returns the status it reports
   function automatic status_type predict_status(input logic [NOW_W-1:0] now,
                                                 input logic pin,
                                                 input logic [ANALOG_W-1:0] sample);
      logic             sensed;
      logic             press;
      logic [NOW_W-1:0] thr;
      logic [NOW_W-1:0] period;
      logic [NOW_W-1:0] elapsed;
      int               c;
      int               v;
      if (now < btn_last_ms) btn_last_ms = '0;
      if (cfg_kind == KIND_NULL) begin
         btn_status = ST_UP;
      end else if (cfg_kind == KIND_AUTO) begin
         period = 32'(CLICK_RATIO) * {16'd0, cfg_repeat};
         if (now < btn_down_ms) btn_down_ms = '0;
         if (btn_down_ms < btn_last_ms) btn_down_ms = btn_last_ms;
         elapsed = now - btn_down_ms;
         if (elapsed > period) begin
            btn_down_ms = now;
            btn_status = ST_RELEASED;
         end else begin
            btn_status = ST_DOWN;
         end
      end else begin
         if (cfg_kind == KIND_ANALOG) begin
            c = int'(cfg_center);
            v = int'(sample);
            sensed = (v >= c - 50) && (v <= c + 50);
         end else begin
            sensed = pin;
         end
         press = (sensed == cfg_level);
         elapsed = now - btn_down_ms;
         case (btn_status)
            ST_UP: begin
               btn_holding = 1'b0;
               btn_repeats = '0;
               if (press) begin
                  btn_status = ST_DEBOUNCE;
                  btn_down_ms = now;
                  btn_last_ms = now;
               end
            end
            ST_DEBOUNCE: begin
               if (!press) btn_status = ST_UP;
               else if (elapsed > {16'd0, cfg_debounce}) btn_status = ST_DOWN;
            end
            ST_DOWN: begin
               if (!press) begin
                  btn_status = btn_holding ? ST_UP : ST_RELEASED;
               end else begin
                  if (!btn_holding) thr = {16'd0, cfg_hold};
                  else if (btn_repeats > cfg_dash_count) thr = {16'd0, cfg_dash};
                  else thr = {16'd0, cfg_repeat};
                  if (elapsed > thr) begin
                     btn_status = ST_HELD;
                     if (btn_repeats <= cfg_dash_count && btn_repeats < 8'd255)
                        btn_repeats = btn_repeats + 8'd1;
                  end
               end
               btn_last_ms = now;
            end
            ST_HELD: begin
               btn_holding = 1'b1;
               if (press) begin
                  btn_status = ST_DOWN;
                  btn_down_ms = now;
               end else begin
                  btn_status = ST_RELEASED;
               end
               btn_last_ms = now;
            end
            ST_RELEASED: begin
               btn_status = ST_UP;
               btn_last_ms = now;
               btn_holding = 1'b0;
               btn_repeats = '0;
            end
            default: ;
         endcase
      end
      return btn_status;
   endfunction

   // driver: a stalled beat holds; a new beat is loaded only after acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            status_due.push_back(predict_status(req_now_ms, req_pin_level,
                                                req_analog_sample));
         if (!req_valid || !req_stall) begin
            if (sample_queue.size() != 0 && !take_break()) begin
               drv_beat = sample_queue.pop_front();
               req_valid <= 1'b1;
               req_now_ms <= drv_beat.now_ms;
               req_pin_level <= drv_beat.pin_level;
               req_analog_sample <= drv_beat.analog_sample;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_due.size() == 0) begin
               report_mismatch($sformatf("status %0d with nothing expected",
                                         rsp_button_status));
            end else begin
               mon_want = status_due.pop_front();
               if (rsp_button_status !== mon_want)
                  report_mismatch($sformatf("button_status got %0d want %0d",
                                            rsp_button_status, mon_want));
            end
         end
         rsp_stall <= take_break();
      end
   end

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DAT_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_BUTTON_KIND:   cfg_kind = data[KIND_W-1:0];
         CSR_PRESSED_LEVEL: cfg_level = data[0];
         CSR_ANALOG_CENTER: cfg_center = data[ANALOG_W-1:0];
         CSR_DEBOUNCE_TIME: cfg_debounce = data;
         CSR_HOLD_TIME:     cfg_hold = data;
         CSR_REPEAT_TIME:   cfg_repeat = data;
         CSR_DASH_TIME:     cfg_dash = data;
         CSR_DASH_COUNT:    cfg_dash_count = data[COUNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_setup(input kind_type kind, input logic level,
                              input int center, input int deb, input int hold,
                              input int rep, input int dash, input int dcount);
      write_reg(CSR_BUTTON_KIND, 16'(kind));
      write_reg(CSR_PRESSED_LEVEL, 16'(level));
      write_reg(CSR_ANALOG_CENTER, 16'(center));
      write_reg(CSR_DEBOUNCE_TIME, 16'(deb));
      write_reg(CSR_HOLD_TIME, 16'(hold));
      write_reg(CSR_REPEAT_TIME, 16'(rep));
      write_reg(CSR_DASH_TIME, 16'(dash));
      write_reg(CSR_DASH_COUNT, 16'(dcount));
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      while ((sample_queue.size() != 0 || req_valid || status_due.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (DRAIN_TAIL) @(negedge clock);
   endtask

   task automatic push_raw(input logic [NOW_W-1:0] now, input logic pin,
                           input logic [ANALOG_W-1:0] sample);
      press_sample_type s;
      s.now_ms = now;
      s.pin_level = pin;
      s.analog_sample = sample;
      sample_queue.push_back(s);
      pushed++;
   endtask

   // one sample at the current setting, pressed or not
   task automatic tick(input logic press);
      int   lo;
      int   hi;
      logic pin;
      logic inwin;
      logic [ANALOG_W-1:0] sample;
      stamp = stamp + $urandom_range(gap_max);
      lo = (cfg_center < 50) ? 0 : cfg_center - 50;
      hi = (cfg_center > 973) ? 1023 : cfg_center + 50;
      pin = press ? cfg_level : ~cfg_level;
      sample = 10'($urandom_range(1023));
      if (cfg_kind == KIND_ANALOG) begin
         pin = 1'($urandom_range(1));
         inwin = press ? cfg_level : ~cfg_level;
         if (inwin) sample = 10'($urandom_range(hi, lo));
         else if (lo == 0) sample = 10'($urandom_range(1023, hi + 1));
         else if (hi == 1023 || $urandom_range(1)) sample = 10'($urandom_range(lo - 1, 0));
         else sample = 10'($urandom_range(1023, hi + 1));
      end
      push_raw(stamp, pin, sample);
   endtask

   task automatic burst(input int count);
      int goal;
      int pick;
      int len;
      goal = pushed + count;
      while (pushed < goal) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            // clean press and release
            len = $urandom_range(40, 1);
            repeat (len) tick(1'b1);
            len = $urandom_range(3, 1);
            repeat (len) tick(1'b0);
         end else if (pick < 85) begin
            stamp = $urandom;
            push_raw(stamp, 1'($urandom_range(1)), 10'($urandom_range(1023)));
         end else if (pick < 93) begin
            // contact bounce
            len = $urandom_range(4, 1);
            repeat (len) begin
               tick(1'b1);
               tick(1'b0);
            end
         end else begin
            stamp = stamp - $urandom_range(40, 1);
            tick(1'($urandom_range(1)));
         end
      end
   endtask

   task automatic pick_setup();
      int       k;
      kind_type kind;
      int       center;
      k = $urandom_range(9);
      if (k < 4) kind = KIND_DIGITAL;
      else if (k < 7) kind = KIND_ANALOG;
      else if (k < 8) kind = KIND_NULL;
      else kind = KIND_AUTO;
      center = $urandom_range(1023);
      if ($urandom_range(3) == 0) center = $urandom_range(1) ? 1023 : 0;
      apply_setup(kind, 1'($urandom_range(1)), center, $urandom_range(6),
                  $urandom_range(25), $urandom_range(10), $urandom_range(4),
                  $urandom_range(6));
      gap_max = $urandom_range(8, 2);
   endtask

   initial begin
      int phase;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset setting: pin low is pressed, debounce 50, hold 1000, repeat 200
      push_raw(32'd0, 1'b1, 10'd0);
      push_raw(32'd100, 1'b0, 10'd1023);
      push_raw(32'd150, 1'b0, 10'd0);         // exactly at debounce, still bouncing
      push_raw(32'd151, 1'b0, 10'd512);
      push_raw(32'd1100, 1'b0, 10'd0);
      push_raw(32'd1101, 1'b0, 10'd0);        // first hold
      push_raw(32'd1102, 1'b0, 10'd0);
      push_raw(32'd1303, 1'b0, 10'd0);        // repeat
      push_raw(32'd1304, 1'b0, 10'd0);
      push_raw(32'd1305, 1'b1, 10'd0);        // let go while holding: straight up
      push_raw(32'd50, 1'b0, 10'd0);          // time ran backwards
      push_raw(32'd40, 1'b1, 10'd0);
      push_raw(32'hFFFF_FFF0, 1'b0, 10'd0);
      push_raw(32'h0000_0030, 1'b0, 10'd0);   // wraps past zero
      push_raw(32'hFFFF_FFFF, 1'b1, 10'd0);   // released
      push_raw(32'hFFFF_FFFF, 1'b1, 10'd0);
      drain();
      // analog window edges around 512
      write_reg(CSR_BUTTON_KIND, 16'(KIND_ANALOG));
      write_reg(CSR_PRESSED_LEVEL, 16'd1);
      push_raw(32'd2000, 1'b0, 10'd462);
      push_raw(32'd2001, 1'b1, 10'd563);
      push_raw(32'd2002, 1'b0, 10'd562);
      push_raw(32'd2003, 1'b1, 10'd461);
      drain();
      write_reg(CSR_BUTTON_KIND, 16'(KIND_AUTO));
      push_raw(32'd3000, 1'b0, 10'd0);
      push_raw(32'd3100, 1'b1, 10'd1023);
      push_raw(32'd3901, 1'b0, 10'd0);
      drain();
      write_reg(CSR_BUTTON_KIND, 16'(KIND_NULL));
      push_raw(32'd4000, 1'b0, 10'd511);
      drain();

      stamp = 32'd5000;
      for (phase = 0; phase < 9; phase++) begin
         case (phase)
            0: begin
               apply_setup(KIND_DIGITAL, 1'b0, 0, 0, 0, 0, 0, 0);
               gap_max = 3;
            end
            1: begin
               apply_setup(KIND_ANALOG, 1'b1, 1023, 65535, 65535, 65535, 65535, 254);
               gap_max = 70000;
            end
            2: begin
               apply_setup(KIND_AUTO, 1'b1, 0, 65535, 65535, 65535, 65535, 254);
               gap_max = 140000;
            end
            default: begin
               pick_setup();
            end
         endcase
         calm = (phase == 4);
         burst(30);
         drain();
      end
      calm = 1'b0;

      if (status_due.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", status_due.size()));
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[button_debounce_hold_repeat.f]
rtl/core/bdhr_pkg.sv
rtl/core/button_debounce_hold_repeat.sv
rtl/core/bdhr_checker.sv
tb/tb.sv
